// File: rtl/core/tdcu_pkg.sv
// tdcu_pkg: shared types and constants for the TDC event word unpacker.
// No dependencies; used by every module under rtl/core except tdcu_ram.
package tdcu_pkg;

  localparam int MAP_DEPTH    = 64;
  localparam int PARAM_SLOTS  = 4096;
  localparam int MAP_AW       = $clog2(MAP_DEPTH);
  localparam int TARGET_W     = 13;
  localparam int PID_W        = 12;
  localparam int VALUE_W      = 30;
  localparam int WORD_W       = 32;
  localparam int ID_W         = 8;
  localparam int SLOT_W       = 6;
  localparam int TRAILER_SLOT = 32;

  typedef enum logic [1:0] {
    WT_DATA    = 2'b00,
    WT_HEADER  = 2'b01,
    WT_OTHER   = 2'b10,
    WT_TRAILER = 2'b11
  } word_type_t;

  typedef struct packed {
    logic                 valid;
    logic                 is_count;
    logic [VALUE_W-1:0]   value;
  } stage_t;

  typedef struct packed {
    logic                 rd_en;
    logic [MAP_AW-1:0]    addr;
  } lookup_t;

endpackage

// File: rtl/core/tdc_event_word_unpacker.sv
// Unpacks TDC readout longwords into parameter id / value transactions.
// Depends on tdcu_pkg, tdcu_parse, tdcu_map, tdcu_emit, tdcu_ram.
//
// Input channel item_valid/item_stall carries mode, data_word, map_slot and
// map_target. mode 0 parses data_word; mode 1 writes one channel map entry.
// Output channel result_valid/result_stall carries param_id, param_value and
// is_count; a data word with an unmapped channel, a trailer with map slot 32
// unmapped or a skipped word gives no transaction. cfg_valid/cfg_ready writes
// the 8-bit module id (cfg_ready is always high).
// Throughput: one item per cycle while item_stall is low. A taken item passes
// the registered read of the channel map RAM, together with the first stage,
// and then the result register before its result is presented.
// Reset (rst, synchronous) returns the parser to awaiting a header, marks all
// map entries unmapped through per-entry valid bits and clears module id.
// When result_stall holds a result, one more item may sit in the first
// stage; after that item_stall is raised until the result is taken.
module tdc_event_word_unpacker (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 item_valid,
  output logic                                 item_stall,
  input  logic                                 mode,
  input  logic [tdcu_pkg::WORD_W-1:0]          data_word,
  input  logic [tdcu_pkg::SLOT_W-1:0]          map_slot,
  input  logic signed [tdcu_pkg::TARGET_W-1:0] map_target,
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output logic [tdcu_pkg::PID_W-1:0]           param_id,
  output logic [tdcu_pkg::VALUE_W-1:0]         param_value,
  output logic                                 is_count,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [tdcu_pkg::ID_W-1:0]            cfg_data
);

  logic                          accept;
  logic                          advance;
  logic                          hit;
  logic [tdcu_pkg::PID_W-1:0]    pid;
  logic [tdcu_pkg::ID_W-1:0]     module_id;
  tdcu_pkg::stage_t              s1;
  tdcu_pkg::lookup_t             lookup;

  assign cfg_ready  = 1'b1;
  assign item_stall = s1.valid && !advance;
  assign accept     = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      module_id <= '0;
    end else if (cfg_valid && cfg_ready) begin
      module_id <= cfg_data;
    end
  end

  tdcu_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .mode      (mode),
    .data_word (data_word),
    .module_id (module_id),
    .advance   (advance),
    .s1        (s1),
    .lookup    (lookup)
  );

  tdcu_map u_map (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (accept && mode),
    .wr_slot   (map_slot),
    .wr_target (map_target),
    .lookup    (lookup),
    .hit       (hit),
    .pid       (pid)
  );

  tdcu_emit u_emit (
    .clk          (clk),
    .rst          (rst),
    .s1           (s1),
    .hit          (hit),
    .pid          (pid),
    .result_stall (result_stall),
    .advance      (advance),
    .result_valid (result_valid),
    .param_id     (param_id),
    .param_value  (param_value),
    .is_count     (is_count)
  );

`ifndef ASSERT_OFF
  a_stall_needs_stage: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> s1.valid && result_valid)
    else $error("input stalled with free pipeline");
  a_data_value_narrow: assert property (@(posedge clk) disable iff (rst)
    result_valid && !is_count |-> param_value[tdcu_pkg::VALUE_W-1:16] == '0)
    else $error("data value wider than 16 bits");
  a_no_lost_stage: assert property (@(posedge clk) disable iff (rst)
    s1.valid && !advance |=> s1.valid && $stable(s1.value))
    else $error("stage-1 transaction dropped while stalled");
`endif

endmodule

// File: rtl/core/tdcu_ram.sv
// tdcu_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module tdcu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/core/tdcu_map.sv
// tdcu_map: channel map storage with per-entry valid bits and mapped check.
// Depends on tdcu_pkg and tdcu_ram.
module tdcu_map (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              wr_en,
  input  logic [tdcu_pkg::SLOT_W-1:0]       wr_slot,
  input  logic signed [tdcu_pkg::TARGET_W-1:0] wr_target,
  input  tdcu_pkg::lookup_t                 lookup,
  output logic                              hit,
  output logic [tdcu_pkg::PID_W-1:0]        pid
);

  logic [tdcu_pkg::MAP_DEPTH-1:0] vld;
  logic                           rd_vld;
  logic [tdcu_pkg::TARGET_W-1:0]  rd_data;
  logic                           wr_ok;

  assign wr_ok = wr_en && (32'(wr_slot) < tdcu_pkg::MAP_DEPTH);

  tdcu_ram #(
    .WIDTH (tdcu_pkg::TARGET_W),
    .DEPTH (tdcu_pkg::MAP_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_ok),
    .wr_addr (wr_slot[tdcu_pkg::MAP_AW-1:0]),
    .wr_data (wr_target),
    .rd_en   (lookup.rd_en),
    .rd_addr (lookup.addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr_ok) begin
      vld[wr_slot[tdcu_pkg::MAP_AW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (lookup.rd_en) begin
      rd_vld <= vld[lookup.addr];
    end
  end

  // negative target = unmapped
  assign hit = rd_vld && !rd_data[tdcu_pkg::TARGET_W-1] &&
               (32'(rd_data[tdcu_pkg::PID_W-1:0]) < tdcu_pkg::PARAM_SLOTS);
  assign pid = rd_data[tdcu_pkg::PID_W-1:0];

endmodule

// File: rtl/core/tdcu_parse.sv
// tdcu_parse: event framing state machine and first pipeline stage.
// Depends on tdcu_pkg.
module tdcu_parse (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic                          mode,
  input  logic [tdcu_pkg::WORD_W-1:0]   data_word,
  input  logic [tdcu_pkg::ID_W-1:0]     module_id,
  input  logic                          advance,
  output tdcu_pkg::stage_t              s1,
  output tdcu_pkg::lookup_t             lookup
);

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_BODY,
    PH_SKIP
  } phase_t;

  phase_t               phase, phase_next;
  tdcu_pkg::word_type_t wtype;
  tdcu_pkg::stage_t     cand;
  logic                 parse_en;
  logic [5:0]           channel;

  assign parse_en = accept && !mode;
  assign wtype    = tdcu_pkg::word_type_t'(data_word[31:30]);
  assign channel  = data_word[21:16];

  always_comb begin
    phase_next     = phase;
    cand           = '0;
    lookup.rd_en   = 1'b0;
    lookup.addr    = channel[tdcu_pkg::MAP_AW-1:0];
    unique case (phase)
      PH_HEADER: begin
        if (data_word != '1 && wtype == tdcu_pkg::WT_HEADER &&
            data_word[23:16] == module_id) begin
          phase_next = PH_BODY;
        end
      end
      PH_BODY: begin
        if (wtype == tdcu_pkg::WT_DATA) begin
          cand.valid    = (32'(channel) < tdcu_pkg::MAP_DEPTH);
          cand.value    = tdcu_pkg::VALUE_W'(data_word[15:0]);
        end else begin
          phase_next = PH_SKIP;
          if (wtype == tdcu_pkg::WT_TRAILER) begin
            cand.valid    = 1'b1;
            cand.is_count = 1'b1;
            cand.value    = data_word[tdcu_pkg::VALUE_W-1:0];
            lookup.addr   = tdcu_pkg::MAP_AW'(tdcu_pkg::TRAILER_SLOT);
          end
        end
      end
      PH_SKIP: phase_next = PH_HEADER;
      default: phase_next = PH_HEADER;
    endcase
    lookup.rd_en = parse_en && cand.valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_HEADER;
      s1.valid <= 1'b0;
    end else begin
      if (parse_en) begin
        phase <= phase_next;
      end
      if (parse_en && cand.valid) begin
        s1 <= cand;
      end else if (advance) begin
        s1.valid <= 1'b0;
      end
    end
  end

`ifndef ASSERT_OFF
  a_count_ends_body: assert property (@(posedge clk) disable iff (rst)
    parse_en && phase == PH_BODY && wtype == tdcu_pkg::WT_TRAILER |=> phase == PH_SKIP)
    else $error("trailer did not end event body");
  a_foreign_ignored: assert property (@(posedge clk) disable iff (rst)
    parse_en && phase == PH_HEADER && data_word[23:16] != module_id |=> phase == PH_HEADER)
    else $error("header with foreign id opened a body");
  a_lookup_with_stage: assert property (@(posedge clk) disable iff (rst)
    lookup.rd_en |=> s1.valid)
    else $error("map read issued without a stage-1 transaction");
`endif

endmodule

// File: rtl/core/tdcu_emit.sv
// tdcu_emit: result register and output handshake.
// Depends on tdcu_pkg.
module tdcu_emit (
  input  logic                          clk,
  input  logic                          rst,
  input  tdcu_pkg::stage_t              s1,
  input  logic                          hit,
  input  logic [tdcu_pkg::PID_W-1:0]    pid,
  input  logic                          result_stall,
  output logic                          advance,
  output logic                          result_valid,
  output logic [tdcu_pkg::PID_W-1:0]    param_id,
  output logic [tdcu_pkg::VALUE_W-1:0]  param_value,
  output logic                          is_count
);

  assign advance = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= s1.valid && hit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1.valid) begin
      param_id    <= pid;
      param_value <= s1.value;
      is_count    <= s1.is_count;
    end
  end

endmodule

// File: tb/tb_tdc_event_word_unpacker.sv
// tb_tdc_event_word_unpacker: self-checking testbench for the TDC event word unpacker.
// Depends on tdcu_pkg and tdc_event_word_unpacker; drives directed and random readout
// streams and compares every output transaction against an in-bench parser and map model.
module tb_tdc_event_word_unpacker;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_ITEMS  = 210;

  typedef enum logic [1:0] {PH_HEADER, PH_BODY, PH_SKIP} parse_phase_t;

  typedef struct {
    logic                                 mode;
    logic [tdcu_pkg::WORD_W-1:0]          word;
    logic [tdcu_pkg::SLOT_W-1:0]          slot;
    logic signed [tdcu_pkg::TARGET_W-1:0] target;
  } feed_item_t;

  typedef struct {
    logic [tdcu_pkg::PID_W-1:0]   pid;
    logic [tdcu_pkg::VALUE_W-1:0] value;
    logic                         is_count;
  } param_xfer_t;

  logic                                 clk = 1'b0;
  logic                                 rst = 1'b1;
  logic                                 item_valid = 1'b0;
  logic                                 item_stall;
  logic                                 mode = 1'b0;
  logic [tdcu_pkg::WORD_W-1:0]          data_word = '0;
  logic [tdcu_pkg::SLOT_W-1:0]          map_slot = '0;
  logic signed [tdcu_pkg::TARGET_W-1:0] map_target = '0;
  logic                                 result_valid;
  logic                                 result_stall = 1'b0;
  logic [tdcu_pkg::PID_W-1:0]           param_id;
  logic [tdcu_pkg::VALUE_W-1:0]         param_value;
  logic                                 is_count;
  logic                                 cfg_valid = 1'b0;
  logic                                 cfg_ready;
  logic [tdcu_pkg::ID_W-1:0]            cfg_data = '0;

  logic [tdcu_pkg::ID_W-1:0]            id_model = '0;
  parse_phase_t                         phase_model = PH_HEADER;
  logic signed [tdcu_pkg::TARGET_W-1:0] map_model [tdcu_pkg::MAP_DEPTH];

  feed_item_t  word_queue [$];
  param_xfer_t param_queue [$];
  feed_item_t  on_bus;

  int idle_pct = 37;
  int stall_pct = 37;
  bit hold_arm = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;

  int errors = 0;
  int cycles = 0;
  int n_items = 0;
  int n_params = 0;
  int n_counts = 0;
  int n_maps = 0;
  int n_events = 0;

  always #6 clk = ~clk;

  tdc_event_word_unpacker uut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .mode         (mode),
    .data_word    (data_word),
    .map_slot     (map_slot),
    .map_target   (map_target),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .param_id     (param_id),
    .param_value  (param_value),
    .is_count     (is_count),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  function automatic bit map_lookup(input int slot,
                                    output logic [tdcu_pkg::PID_W-1:0] pid);
    logic signed [tdcu_pkg::TARGET_W-1:0] t;
    pid = '0;
    if (slot >= tdcu_pkg::MAP_DEPTH) return 1'b0;
    t = map_model[slot];
    if (t < 0 || t >= tdcu_pkg::PARAM_SLOTS) return 1'b0;
    pid = t[tdcu_pkg::PID_W-1:0];
    return 1'b1;
  endfunction

  task automatic unpack_word(input feed_item_t it);
    tdcu_pkg::word_type_t       wt;
    logic [tdcu_pkg::PID_W-1:0] pid;
    param_xfer_t                r;
    if (it.mode) begin
      if (it.slot < tdcu_pkg::MAP_DEPTH) map_model[it.slot] = it.target;
      n_maps++;
      return;
    end
    wt = tdcu_pkg::word_type_t'(it.word[31:30]);
    case (phase_model)
      PH_HEADER: begin
        if (it.word != '1 && wt == tdcu_pkg::WT_HEADER && it.word[23:16] == id_model)
          phase_model = PH_BODY;
      end
      PH_BODY: begin
        if (wt == tdcu_pkg::WT_DATA) begin
          if (map_lookup(it.word[21:16], pid)) begin
            r.pid = pid;
            r.value = tdcu_pkg::VALUE_W'(it.word[15:0]);
            r.is_count = 1'b0;
            param_queue.push_back(r);
          end
        end else begin
          phase_model = PH_SKIP;
          if (wt == tdcu_pkg::WT_TRAILER && map_lookup(tdcu_pkg::TRAILER_SLOT, pid)) begin
            r.pid = pid;
            r.value = it.word[29:0];
            r.is_count = 1'b1;
            param_queue.push_back(r);
            n_counts++;
          end
        end
      end
      default: phase_model = PH_HEADER;
    endcase
  endtask

  task automatic flag(input string msg);
    if (errors < 10) $display("mismatch: %s", msg);
    errors++;
  endtask

  function automatic feed_item_t longword(input logic [tdcu_pkg::WORD_W-1:0] w);
    feed_item_t it;
    it.mode = 1'b0;
    it.word = w;
    it.slot = tdcu_pkg::SLOT_W'($urandom);
    it.target = tdcu_pkg::TARGET_W'($urandom);
    return it;
  endfunction

  function automatic feed_item_t map_write(input int slot,
                                           input logic signed [tdcu_pkg::TARGET_W-1:0] target);
    feed_item_t it;
    it.mode = 1'b1;
    it.word = $urandom;
    it.slot = tdcu_pkg::SLOT_W'(slot);
    it.target = target;
    return it;
  endfunction

  function automatic logic signed [tdcu_pkg::TARGET_W-1:0] rand_target();
    int r;
    r = $urandom_range(99);
    if (r < 70) return tdcu_pkg::TARGET_W'($urandom_range(tdcu_pkg::PARAM_SLOTS - 1));
    if (r < 85) return '1;
    return {1'b1, 12'($urandom)};
  endfunction

  task automatic queue_event(input logic [tdcu_pkg::ID_W-1:0] id);
    int n;
    int r;
    if ($urandom_range(99) < 20) begin
      n = $urandom_range(1, 3);
      repeat (n) begin
        r = $urandom_range(3);
        case (r)
          0: word_queue.push_back(longword('1));
          1: word_queue.push_back(longword({2'b01, 6'($urandom),
                                            id ^ tdcu_pkg::ID_W'($urandom_range(1, 255)),
                                            16'($urandom)}));
          default: word_queue.push_back(longword($urandom));
        endcase
      end
    end
    word_queue.push_back(longword({2'b01, 6'($urandom), id, 16'($urandom)}));
    n = $urandom_range(0, 8);
    repeat (n) begin
      if ($urandom_range(99) < 6)
        word_queue.push_back(map_write($urandom_range(tdcu_pkg::MAP_DEPTH - 1),
                                       rand_target()));
      word_queue.push_back(longword({2'b00, 30'($urandom)}));
    end
    r = $urandom_range(99);
    if (r < 80) word_queue.push_back(longword({2'b11, 30'($urandom)}));
    else if (r < 90) word_queue.push_back(longword({2'b01, 30'($urandom)}));
    else word_queue.push_back(longword({2'b10, 30'($urandom)}));
    r = $urandom_range(99);
    if (r < 10) word_queue.push_back(longword('1));
    else if (r < 20) word_queue.push_back(longword({2'b01, 6'($urandom), id, 16'($urandom)}));
    else word_queue.push_back(longword($urandom));
    n_events++;
  endtask

  task automatic queue_phase(input logic [tdcu_pkg::ID_W-1:0] id);
    while (word_queue.size() < PHASE_ITEMS) queue_event(id);
  endtask

  task automatic wait_idle();
    while (word_queue.size() > 0 || item_valid || param_queue.size() > 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_module_id(input logic [tdcu_pkg::ID_W-1:0] id);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= id;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    id_model = id;
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_tdc_event_word_unpacker: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin : driver
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && !item_stall) begin
        unpack_word(on_bus);
        n_items++;
      end
      if (!item_valid || !item_stall) begin
        if (word_queue.size() > 0 && $urandom_range(99) >= idle_pct) begin
          on_bus = word_queue.pop_front();
          item_valid <= 1'b1;
          mode <= on_bus.mode;
          data_word <= on_bus.word;
          map_slot <= on_bus.slot;
          map_target <= on_bus.target;
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    param_xfer_t want;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        n_params++;
        if (param_queue.size() == 0) begin
          flag($sformatf("unexpected transaction pid=%0d value=%0h count=%0b",
                         param_id, param_value, is_count));
        end else begin
          want = param_queue.pop_front();
          if (param_id !== want.pid || param_value !== want.value ||
              is_count !== want.is_count)
            flag($sformatf({"expected pid=%0d value=%0h count=%0b, ",
                            "got pid=%0d value=%0h count=%0b"},
                           want.pid, want.value, want.is_count,
                           param_id, param_value, is_count));
        end
      end
      if (hold_arm && !hold_done) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else begin
        result_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  initial begin : stimulus
    logic [tdcu_pkg::ID_W-1:0] id;
    for (int i = 0; i < tdcu_pkg::MAP_DEPTH; i++) map_model[i] = '1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // module id still at its reset value of zero
    word_queue.push_back(longword(32'h0000_1234));
    word_queue.push_back(longword('1));
    word_queue.push_back(longword(32'h4001_0000));
    word_queue.push_back(longword(32'h8000_0000));
    word_queue.push_back(longword(32'hC000_0000));
    word_queue.push_back(map_write(0, 13'sd4095));
    word_queue.push_back(map_write(63, '0));
    word_queue.push_back(map_write(tdcu_pkg::TRAILER_SLOT, 13'sd100));
    word_queue.push_back(map_write(5, 13'h1000));
    word_queue.push_back(map_write(6, '1));
    word_queue.push_back(longword(32'h4000_0000));
    word_queue.push_back(longword(32'h0000_FFFF));
    word_queue.push_back(longword(32'h003F_0000));
    word_queue.push_back(longword(32'h0005_ABCD));
    word_queue.push_back(longword(32'h0007_1111));
    word_queue.push_back(longword(32'h3FFF_FFFF));
    word_queue.push_back(longword(32'hFFFF_FFFF));
    word_queue.push_back(longword(32'h4000_0000));
    word_queue.push_back(longword(32'h4000_0000));
    word_queue.push_back(longword(32'h7FFF_FFFF));
    word_queue.push_back(longword(32'h0000_0000));
    word_queue.push_back(map_write(tdcu_pkg::TRAILER_SLOT, '1));
    word_queue.push_back(longword(32'h4000_0000));
    word_queue.push_back(longword(32'hC000_0000));
    word_queue.push_back(longword(32'hBFFF_FFFF));
    word_queue.push_back(longword(32'h4000_0000));
    word_queue.push_back(longword(32'hBFFF_FFFF));
    word_queue.push_back(longword('1));
    wait_idle();

    id = 8'hFF;
    write_module_id(id);
    for (int i = 0; i < tdcu_pkg::MAP_DEPTH; i++)
      word_queue.push_back(map_write(i, (i == tdcu_pkg::TRAILER_SLOT) ?
                             tdcu_pkg::TARGET_W'($urandom_range(tdcu_pkg::PARAM_SLOTS - 1)) :
                             rand_target()));
    while (word_queue.size() < PHASE_ITEMS + tdcu_pkg::MAP_DEPTH) queue_event(id);
    wait_idle();

    // no idling on either side
    id = 8'h00;
    write_module_id(id);
    idle_pct = 0;
    stall_pct = 0;
    queue_phase(id);
    wait_idle();
    idle_pct = 37;
    stall_pct = 37;

    // long output hold while input keeps coming
    id = tdcu_pkg::ID_W'($urandom_range(1, 254));
    write_module_id(id);
    queue_phase(id);
    hold_arm = 1'b1;
    wait_idle();

    id = tdcu_pkg::ID_W'($urandom);
    write_module_id(id);
    queue_phase(id);
    wait_idle();

    $display("run: %0d items accepted (%0d map writes, %0d random events), %0d errors",
             n_items, n_maps, n_events, errors);
    $display("run: %0d parameter transactions checked, %0d trailer counts, ids 255/0/random",
             n_params, n_counts);
    if (errors == 0 && param_queue.size() == 0) begin
      $display("tb_tdc_event_word_unpacker: PASS");
    end else begin
      $display("tb_tdc_event_word_unpacker: FAIL");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/tdcu_pkg.sv
rtl/core/tdcu_ram.sv
rtl/core/tdcu_map.sv
rtl/core/tdcu_parse.sv
rtl/core/tdcu_emit.sv
rtl/core/tdc_event_word_unpacker.sv
tb/tb_tdc_event_word_unpacker.sv
